// ===== rtl/qra_pkg.sv =====
// Shared types, constants and term tables for the quaternion rotation accumulator.
`default_nettype none

package qra_pkg;

    // Word format: signed Q2.30
    localparam int W           = 32;
    localparam int F           = W - 2;
    localparam int PERIOD_BITS = 10;
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 10'd100;

    // Accumulator for sums of rounded products (up to four, times two)
    localparam int ACC_BITS  = W + 8;
    // Raw product and rounded product widths
    localparam int PROD_BITS = 2 * W;
    localparam int RP_BITS   = 2 * W - F + 1;
    // Sum of four squares, square root, long-division numerator, partial remainder
    localparam int SUM_BITS  = 2 * W + 2;
    localparam int ROOT_BITS = W + 1;
    localparam int NUM_BITS  = W + F;
    localparam int REM_BITS  = W + 5;
    localparam int ITER_BITS = $clog2(NUM_BITS + 1);

    localparam logic signed [W-1:0] ONE_WORD = {2'b01, {F{1'b0}}};
    localparam logic signed [ACC_BITS-1:0] ONE_ACC =
        {{(ACC_BITS - F - 1){1'b0}}, 1'b1, {F{1'b0}}};

    // Action codes
    localparam logic [2:0] ACT_CLEAR    = 3'd0;
    localparam logic [2:0] ACT_LOAD     = 3'd1;
    localparam logic [2:0] ACT_ACCUM    = 3'd2;
    localparam logic [2:0] ACT_READ_MAT = 3'd3;
    localparam logic [2:0] ACT_READ_TR  = 3'd4;
    localparam logic [2:0] ACT_READ_Q   = 3'd5;

    // Component indexes
    localparam logic [1:0] IX = 2'd0;
    localparam logic [1:0] IY = 2'd1;
    localparam logic [1:0] IZ = 2'd2;
    localparam logic [1:0] IW = 2'd3;

    localparam logic [3:0] LAST_ENTRY = 4'd15;
    localparam logic [1:0] LAST_COMP  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PMUL,
        ST_PWB,
        ST_SQ,
        ST_SQRT,
        ST_DIV,
        ST_ENTRY,
        ST_EMIT,
        ST_QEMIT
    } state_t;

    typedef enum logic [1:0] {
        COEF_ZERO,
        COEF_PLUS,
        COEF_MINUS
    } coef_t;

    // One term of the Hamilton product: operand a/b from given (g) or stored
    typedef struct packed {
        logic       g_a;
        logic [1:0] a;
        logic       g_b;
        logic [1:0] b;
        logic       sub;
    } pterm_t;

    // One rotation matrix entry: base plus two scaled products of stored components
    typedef struct packed {
        logic       one;
        logic [1:0] a1;
        logic [1:0] b1;
        coef_t      c1;
        logic [1:0] a2;
        logic [1:0] b2;
        coef_t      c2;
    } eterm_t;

    // Control into the divide and square root unit
    typedef struct packed {
        logic start_sqrt;
        logic start_div;
        logic neg;
    } ds_ctrl_t;

    // Status out of the divide and square root unit
    typedef struct packed {
        logic busy;
        logic done;
    } ds_stat_t;

    // Terms of given*stored, four per result component
    function automatic pterm_t pmul_term(input logic [3:0] k);
        pterm_t t;
        unique case (k)
            4'd0:  t = '{1'b0, IX, 1'b1, IW, 1'b0};
            4'd1:  t = '{1'b1, IX, 1'b0, IW, 1'b0};
            4'd2:  t = '{1'b1, IY, 1'b0, IZ, 1'b0};
            4'd3:  t = '{1'b1, IZ, 1'b0, IY, 1'b1};
            4'd4:  t = '{1'b0, IY, 1'b1, IW, 1'b0};
            4'd5:  t = '{1'b1, IY, 1'b0, IW, 1'b0};
            4'd6:  t = '{1'b1, IZ, 1'b0, IX, 1'b0};
            4'd7:  t = '{1'b1, IX, 1'b0, IZ, 1'b1};
            4'd8:  t = '{1'b0, IZ, 1'b1, IW, 1'b0};
            4'd9:  t = '{1'b1, IZ, 1'b0, IW, 1'b0};
            4'd10: t = '{1'b1, IX, 1'b0, IY, 1'b0};
            4'd11: t = '{1'b1, IY, 1'b0, IX, 1'b1};
            4'd12: t = '{1'b1, IW, 1'b0, IW, 1'b0};
            4'd13: t = '{1'b1, IX, 1'b0, IX, 1'b1};
            4'd14: t = '{1'b1, IY, 1'b0, IY, 1'b1};
            default: t = '{1'b1, IZ, 1'b0, IZ, 1'b1};
        endcase
        return t;
    endfunction

    // Row-major rotation matrix entries
    function automatic eterm_t entry_term(input logic [3:0] i);
        eterm_t t;
        unique case (i)
            4'd0:  t = '{1'b1, IY, IY, COEF_MINUS, IZ, IZ, COEF_MINUS};
            4'd1:  t = '{1'b0, IX, IY, COEF_PLUS,  IZ, IW, COEF_PLUS};
            4'd2:  t = '{1'b0, IZ, IX, COEF_PLUS,  IY, IW, COEF_MINUS};
            4'd4:  t = '{1'b0, IX, IY, COEF_PLUS,  IZ, IW, COEF_MINUS};
            4'd5:  t = '{1'b1, IZ, IZ, COEF_MINUS, IX, IX, COEF_MINUS};
            4'd6:  t = '{1'b0, IY, IZ, COEF_PLUS,  IX, IW, COEF_PLUS};
            4'd8:  t = '{1'b0, IZ, IX, COEF_PLUS,  IY, IW, COEF_PLUS};
            4'd9:  t = '{1'b0, IY, IZ, COEF_PLUS,  IX, IW, COEF_MINUS};
            4'd10: t = '{1'b1, IY, IY, COEF_MINUS, IX, IX, COEF_MINUS};
            4'd15: t = '{1'b1, IX, IX, COEF_ZERO,  IX, IX, COEF_ZERO};
            default: t = '{1'b0, IX, IX, COEF_ZERO, IX, IX, COEF_ZERO};
        endcase
        return t;
    endfunction

    // Clamp an accumulator value to the word range
    function automatic logic signed [W-1:0] sat_word(input logic signed [ACC_BITS-1:0] v);
        logic [ACC_BITS-W:0] top;
        logic signed [W-1:0] r;
        top = v[ACC_BITS-1:W-1];
        if (&top || ~|top)
            r = v[W-1:0];
        else if (v[ACC_BITS-1])
            r = {1'b1, {(W-1){1'b0}}};
        else
            r = {1'b0, {(W-1){1'b1}}};
        return r;
    endfunction

    // Scale a rounded product by the entry coefficient
    function automatic logic signed [ACC_BITS-1:0] coef_term(
        input coef_t                       c,
        input logic signed [ACC_BITS-1:0] p
    );
        logic signed [ACC_BITS-1:0] r;
        unique case (c)
            COEF_PLUS:  r = p <<< 1;
            COEF_MINUS: r = -(p <<< 1);
            default:    r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/qra_mul.sv =====
// Shared sign-magnitude multiplier with a registered product.
`default_nettype none

module qra_mul
    import qra_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic signed [W-1:0]   a,
    input  wire logic signed [W-1:0]   b,
    output logic         [PROD_BITS-1:0] prod,
    output logic                       neg
);

    logic [W-1:0] a_mag;
    logic [W-1:0] b_mag;

    // Take magnitudes; the most negative word maps to its unsigned magnitude
    assign a_mag = a[W-1] ? W'(-a) : W'(a);
    assign b_mag = b[W-1] ? W'(-b) : W'(b);

    // Register magnitude product and sign
    always_ff @(posedge clk)
    begin
        prod <= PROD_BITS'(a_mag) * PROD_BITS'(b_mag);
        neg  <= a[W-1] ^ b[W-1];
    end

endmodule

`default_nettype wire

// ===== rtl/qra_divsqrt.sv =====
// Iterative square root and rounded divide sharing one compare and subtract.
`default_nettype none

module qra_divsqrt
    import qra_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ds_ctrl_t              ctrl,
    input  wire logic [SUM_BITS-1:0]   radicand,
    input  wire logic [W-1:0]          numer_mag,
    input  wire logic [ROOT_BITS-1:0]  divisor,
    output ds_stat_t                   stat,
    output logic [ROOT_BITS-1:0]       root,
    output logic signed [W-1:0]        quotient
);

    logic                  busy_reg;
    logic                  done_reg;
    logic                  sqrt_reg;
    logic                  neg_reg;
    logic [ITER_BITS-1:0]  cnt_reg;
    logic [SUM_BITS-1:0]   src_reg;
    logic [REM_BITS-1:0]   rem_reg;
    logic [NUM_BITS-1:0]   q_reg;
    logic [ROOT_BITS-1:0]  div_reg;

    logic [REM_BITS-1:0]   rem_sh;
    logic [REM_BITS-1:0]   trial;
    logic                  ge;
    logic [NUM_BITS-1:0]   numer;
    logic [W-1:0]          q_cap;
    logic                  over;

    // Bring down two radicand bits or one numerator bit
    always_comb
    begin
        if (sqrt_reg)
        begin
            rem_sh = {rem_reg[REM_BITS-3:0], src_reg[SUM_BITS-1:SUM_BITS-2]};
            trial  = {q_reg[REM_BITS-3:0], 2'b01};
        end
        else
        begin
            rem_sh = {rem_reg[REM_BITS-2:0], src_reg[SUM_BITS-1]};
            trial  = REM_BITS'(div_reg);
        end
        ge = rem_sh >= trial;
    end

    // Numerator |c| * 2^F plus half the divisor for rounding
    assign numer = {numer_mag, {F{1'b0}}} + NUM_BITS'(divisor >> 1);

    // Control: busy and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start_sqrt)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ITER_BITS'(ROOT_BITS);
            end
            else if (ctrl.start_div)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ITER_BITS'(NUM_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ITER_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then one digit per cycle
    always_ff @(posedge clk)
    begin
        if (ctrl.start_sqrt)
        begin
            sqrt_reg <= 1'b1;
            src_reg  <= radicand;
            rem_reg  <= '0;
            q_reg    <= '0;
        end
        else if (ctrl.start_div)
        begin
            sqrt_reg <= 1'b0;
            neg_reg  <= ctrl.neg;
            div_reg  <= divisor;
            src_reg  <= {numer, {(SUM_BITS-NUM_BITS){1'b0}}};
            rem_reg  <= '0;
            q_reg    <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sh - trial : rem_sh;
            q_reg   <= {q_reg[NUM_BITS-2:0], ge};
            src_reg <= sqrt_reg ? {src_reg[SUM_BITS-3:0], 2'b00}
                                : {src_reg[SUM_BITS-2:0], 1'b0};
        end
    end

    // Cap the quotient at 2^(W-1), then apply sign and clamp
    assign over  = (|q_reg[NUM_BITS-1:W]) || (q_reg[W-1] && (|q_reg[W-2:0]));
    assign q_cap = over ? {1'b1, {(W-1){1'b0}}} : q_reg[W-1:0];

    always_comb
    begin
        if (neg_reg)
            quotient = W'(-q_cap);
        else if (q_cap[W-1])
            quotient = {1'b0, {(W-1){1'b1}}};
        else
            quotient = q_cap;
    end

    assign root      = q_reg[ROOT_BITS-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/quaternion_rotation_accumulator_core.sv =====
// Top level: orientation quaternion accumulator with rotation matrix readout.
//
// Usage: the input channel (in_valid, in_stall) takes one item per operation:
// action plus qx, qy, qz, qw in signed Q2.30. in_stall is high whenever the
// block is working, so items are taken one at a time. Clear and load are
// applied in the idle state. Accumulate runs 16 products through the single
// shared multiplier; every renorm_period+1 accumulates it also renormalizes:
// the four squares are summed, then a square root and 4 divides run in the
// shared divide/root unit. Reads answer on the output channel (out_valid,
// out_stall) with entry_index, entry_value and last: a matrix or transpose
// read gives 16 items, each built from two multiplier products and held
// on the output before the next is started; a quaternion read gives 4 items.
// A stalled output holds its item until taken; the block waits meanwhile.
// Reset sets the identity quaternion, zeroes the renormalization counter
// and sets renorm_period to 100. Write renorm_period with cfg_wr_en and
// cfg_wr_data only while the block is idle.
`default_nettype none

module quaternion_rotation_accumulator_core
    import qra_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_wr_en,
    input  wire logic [PERIOD_BITS-1:0]  cfg_wr_data,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [2:0]              action,
    input  wire logic signed [31:0]      qx,
    input  wire logic signed [31:0]      qy,
    input  wire logic signed [31:0]      qz,
    input  wire logic signed [31:0]      qw,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [3:0]                   entry_index,
    output logic signed [31:0]           entry_value,
    output logic                         last
);

    state_t                     state_reg, state_next;
    logic [4:0]                 step_reg;
    logic [3:0]                 idx_reg;
    logic [PERIOD_BITS-1:0]     period_reg;
    logic [PERIOD_BITS-1:0]     cnt_reg;
    logic signed [W-1:0]        s_reg [4];
    logic signed [W-1:0]        g_reg [4];
    logic signed [W-1:0]        rq_reg [4];
    logic [2:0]                 act_reg;
    logic signed [ACC_BITS-1:0] acc_reg;
    logic [SUM_BITS-1:0]        sum_reg;
    logic [ROOT_BITS-1:0]       mag_reg;
    logic                       out_valid_reg;
    logic [3:0]                 out_index_reg;
    logic signed [W-1:0]        out_value_reg;
    logic                       out_last_reg;

    logic                       accept;
    logic                       out_take;
    logic signed [W-1:0]        mul_a, mul_b;
    logic [PROD_BITS-1:0]       prod;
    logic                       prod_neg;
    logic [PROD_BITS:0]         rsum;
    logic signed [ACC_BITS-1:0] rp;
    pterm_t                     pt_cur, pt_prev;
    logic [3:0]                 pterm_prev_idx;
    logic [3:0]                 entry_src;
    eterm_t                     et;
    logic signed [ACC_BITS-1:0] pacc_in, pacc_new;
    logic signed [ACC_BITS-1:0] ebase, eacc_new;
    logic [SUM_BITS-1:0]        sum_final;
    ds_ctrl_t                   ds_ctrl;
    ds_stat_t                   ds_stat;
    logic [ROOT_BITS-1:0]       ds_root;
    logic signed [W-1:0]        ds_quot;
    logic [1:0]                 div_idx;
    logic [ROOT_BITS-1:0]       div_divisor;
    logic [W-1:0]               div_mag;

    assign accept   = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;

    // Term tables
    assign pterm_prev_idx = 4'(step_reg - 5'd1);
    assign pt_cur         = pmul_term(step_reg[3:0]);
    assign pt_prev        = pmul_term(pterm_prev_idx);
    assign entry_src      = (act_reg == ACT_READ_TR) ? {idx_reg[1:0], idx_reg[3:2]} : idx_reg;
    assign et             = entry_term(entry_src);

    // Select multiplier operands for the current step
    always_comb
    begin
        mul_a = s_reg[IX];
        mul_b = s_reg[IX];
        unique case (state_reg)
            ST_PMUL:
            begin
                mul_a = pt_cur.g_a ? g_reg[pt_cur.a] : s_reg[pt_cur.a];
                mul_b = pt_cur.g_b ? g_reg[pt_cur.b] : s_reg[pt_cur.b];
            end
            ST_SQ:
            begin
                mul_a = s_reg[step_reg[1:0]];
                mul_b = s_reg[step_reg[1:0]];
            end
            ST_ENTRY:
            begin
                mul_a = (step_reg == 5'd0) ? s_reg[et.a1] : s_reg[et.a2];
                mul_b = (step_reg == 5'd0) ? s_reg[et.b1] : s_reg[et.b2];
            end
            default:
            begin
                mul_a = s_reg[IX];
                mul_b = s_reg[IX];
            end
        endcase
    end

    qra_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod),
        .neg  (prod_neg)
    );

    // Round product to the fraction, half away from zero, and apply its sign
    always_comb
    begin
        rsum = {1'b0, prod} + ((PROD_BITS+1)'(1) << (F - 1));
        rp   = prod_neg ? -ACC_BITS'(rsum[PROD_BITS:F]) : ACC_BITS'(rsum[PROD_BITS:F]);
    end

    // Hamilton product accumulation
    assign pacc_in  = (pterm_prev_idx[1:0] == 2'd0) ? '0 : acc_reg;
    assign pacc_new = pt_prev.sub ? pacc_in - rp : pacc_in + rp;

    // Matrix entry accumulation
    assign ebase    = et.one ? ONE_ACC : '0;
    assign eacc_new = (step_reg == 5'd1) ? ebase + coef_term(et.c1, rp)
                                         : acc_reg + coef_term(et.c2, rp);

    assign sum_final = sum_reg + SUM_BITS'(prod);

    // Divide operands: next component to normalize
    assign div_idx     = (state_reg == ST_SQRT) ? IX : 2'(idx_reg[1:0] + 2'd1);
    assign div_divisor = (state_reg == ST_SQRT) ? ds_root : mag_reg;
    assign div_mag     = s_reg[div_idx][W-1] ? W'(-s_reg[div_idx]) : W'(s_reg[div_idx]);

    qra_divsqrt u_divsqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ds_ctrl),
        .radicand  (sum_final),
        .numer_mag (div_mag),
        .divisor   (div_divisor),
        .stat      (ds_stat),
        .root      (ds_root),
        .quotient  (ds_quot)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (action)
                        ACT_ACCUM:    state_next = ST_PMUL;
                        ACT_READ_MAT: state_next = ST_ENTRY;
                        ACT_READ_TR:  state_next = ST_ENTRY;
                        ACT_READ_Q:   state_next = ST_QEMIT;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PMUL:
                if (step_reg == 5'd16)
                    state_next = ST_PWB;
            ST_PWB:
                state_next = (cnt_reg >= period_reg) ? ST_SQ : ST_IDLE;
            ST_SQ:
                if (step_reg == 5'd4)
                    state_next = ST_SQRT;
            ST_SQRT:
                if (ds_stat.done)
                    state_next = (ds_root == '0) ? ST_IDLE : ST_DIV;
            ST_DIV:
                if (ds_stat.done && idx_reg[1:0] == LAST_COMP)
                    state_next = ST_IDLE;
            ST_ENTRY:
                if (step_reg == 5'd2)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (out_take)
                    state_next = (idx_reg == LAST_ENTRY) ? ST_IDLE : ST_ENTRY;
            ST_QEMIT:
                if (out_take && idx_reg[1:0] == LAST_COMP)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Handshake and unit control outputs
    always_comb
    begin
        in_stall           = (state_reg != ST_IDLE);
        ds_ctrl.start_sqrt = (state_reg == ST_SQ) && (step_reg == 5'd4);
        ds_ctrl.start_div  = ds_stat.done &&
                             (((state_reg == ST_SQRT) && (ds_root != '0)) ||
                              ((state_reg == ST_DIV) && (idx_reg[1:0] != LAST_COMP)));
        ds_ctrl.neg        = s_reg[div_idx][W-1];
    end

    // Control state and orientation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            idx_reg       <= '0;
            period_reg    <= PERIOD_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            s_reg[IX]     <= '0;
            s_reg[IY]     <= '0;
            s_reg[IZ]     <= '0;
            s_reg[IW]     <= ONE_WORD;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                period_reg <= cfg_wr_data;
            unique case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    idx_reg  <= '0;
                    if (accept && action == ACT_CLEAR)
                    begin
                        s_reg[IX] <= '0;
                        s_reg[IY] <= '0;
                        s_reg[IZ] <= '0;
                        s_reg[IW] <= ONE_WORD;
                    end
                    else if (accept && action == ACT_LOAD)
                    begin
                        s_reg[IX] <= qx;
                        s_reg[IY] <= qy;
                        s_reg[IZ] <= qz;
                        s_reg[IW] <= qw;
                    end
                end
                ST_PMUL:
                    step_reg <= step_reg + 5'd1;
                ST_PWB:
                begin
                    s_reg    <= rq_reg;
                    step_reg <= '0;
                    if (cnt_reg >= period_reg)
                        cnt_reg <= '0;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                ST_SQ:
                    step_reg <= step_reg + 5'd1;
                ST_SQRT:
                    idx_reg <= '0;
                ST_DIV:
                begin
                    if (ds_stat.done)
                    begin
                        s_reg[idx_reg[1:0]] <= ds_quot;
                        idx_reg             <= idx_reg + 4'd1;
                    end
                end
                ST_ENTRY:
                begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd2)
                        out_valid_reg <= 1'b1;
                end
                ST_EMIT:
                begin
                    if (out_take)
                    begin
                        out_valid_reg <= 1'b0;
                        step_reg      <= '0;
                        idx_reg       <= idx_reg + 4'd1;
                    end
                end
                ST_QEMIT:
                begin
                    if (!out_valid_reg)
                        out_valid_reg <= 1'b1;
                    else if (out_take)
                    begin
                        out_valid_reg <= 1'b0;
                        idx_reg       <= idx_reg + 4'd1;
                    end
                end
                default:
                    step_reg <= '0;
            endcase
        end
    end

    // Payload: captured item, accumulators, output item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= action;
            g_reg[IX] <= qx;
            g_reg[IY] <= qy;
            g_reg[IZ] <= qz;
            g_reg[IW] <= qw;
        end
        if (state_reg == ST_PMUL && step_reg != 5'd0)
        begin
            acc_reg <= pacc_new;
            if (pterm_prev_idx[1:0] == 2'd3)
                rq_reg[pterm_prev_idx[3:2]] <= sat_word(pacc_new);
        end
        if (state_reg == ST_PWB)
            sum_reg <= '0;
        if (state_reg == ST_SQ && step_reg != 5'd0)
            sum_reg <= sum_final;
        if (state_reg == ST_SQRT && ds_stat.done)
            mag_reg <= ds_root;
        if (state_reg == ST_ENTRY && step_reg != 5'd0)
        begin
            acc_reg <= eacc_new;
            if (step_reg == 5'd2)
            begin
                out_value_reg <= sat_word(eacc_new);
                out_index_reg <= idx_reg;
                out_last_reg  <= (idx_reg == LAST_ENTRY);
            end
        end
        if (state_reg == ST_QEMIT && !out_valid_reg)
        begin
            out_value_reg <= s_reg[idx_reg[1:0]];
            out_index_reg <= idx_reg;
            out_last_reg  <= (idx_reg[1:0] == LAST_COMP);
        end
    end

    assign out_valid   = out_valid_reg;
    assign entry_index = out_index_reg;
    assign entry_value = out_value_reg;
    assign last        = out_last_reg;

endmodule

`default_nettype wire
